// ===== sv/variadic_word_class_matcher_macros.svh =====
// assertion macros for the word class matcher
`ifndef VARIADIC_WORD_CLASS_MATCHER_MACROS_SVH
`define VARIADIC_WORD_CLASS_MATCHER_MACROS_SVH

// property checked at every rising clock edge outside reset
`define VWCM_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// same-cycle implication
`define VWCM_ASSERT_IMP(label, ante, cons, msg) \
	`VWCM_ASSERT(label, (ante) |-> (cons), msg)

`endif

// ===== sv/vwcm_pkg.sv =====
// shared types and constants for the word class matcher
`default_nettype none
package vwcm_pkg;

	localparam int MaxPositionsDef = 16;
	localparam int WordCountDef    = 32;
	localparam int CharCount       = 256;
	localparam int ReqAddrW        = 14;
	localparam int ReqBitsW        = 32;

	typedef enum logic [2:0] {
		K_MATCH     = 3'd0,
		K_RANGE     = 3'd1,
		K_RANGE_REP = 3'd2,
		K_SUFFIX    = 3'd3,
		K_REMOVE    = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RUN
	} state_t;

	typedef enum logic [1:0] {
		OP_READ,
		OP_OR,
		OP_ANDN,
		OP_ZERO
	} op_t;

	typedef struct packed {
		logic                valid;
		op_t                 op;
		logic                pos_en;
		logic                sfx_en;
		logic [ReqAddrW-1:0] pos_addr;
		logic [7:0]          sfx_addr;
		logic [ReqBitsW-1:0] bits;
	} mem_req_t;

endpackage
`default_nettype wire

// ===== sv/vwcm_store.sv =====
// position and suffix table memories with read-modify-write stage
`default_nettype none
module vwcm_store import vwcm_pkg::*; #(
	parameter int MAX_POSITIONS = MaxPositionsDef,
	parameter int WORD_COUNT    = WordCountDef
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire mem_req_t              req,
	output logic [WORD_COUNT-1:0]      pos_rdata,
	output logic [WORD_COUNT-1:0]      sfx_rdata
);

	localparam int PW    = (MAX_POSITIONS > 1) ? $clog2(MAX_POSITIONS) : 1;
	localparam int AW    = PW + 8;
	localparam int Depth = MAX_POSITIONS * CharCount;

	logic [WORD_COUNT-1:0] pos_mem [Depth];
	logic [WORD_COUNT-1:0] sfx_mem [CharCount];

	logic                  wb_s1;
	logic                  pos_s1;
	logic                  sfx_s1;
	op_t                   op_s1;
	logic [AW-1:0]         pos_addr_s1;
	logic [7:0]            sfx_addr_s1;
	logic [WORD_COUNT-1:0] bits_s1;

	logic                  issue;
	logic                  zero_wr;
	logic                  pos_we;
	logic                  sfx_we;
	logic [AW-1:0]         pos_wa;
	logic [7:0]            sfx_wa;
	logic [WORD_COUNT-1:0] pos_wd;
	logic [WORD_COUNT-1:0] sfx_wd;

	assign issue   = req.valid && (req.op != OP_ZERO);
	assign zero_wr = req.valid && (req.op == OP_ZERO);

	always_comb begin
		pos_we = 1'b0;
		sfx_we = 1'b0;
		pos_wa = pos_addr_s1;
		sfx_wa = sfx_addr_s1;
		pos_wd = '0;
		sfx_wd = '0;
		if (zero_wr) begin
			pos_we = req.pos_en;
			sfx_we = req.sfx_en;
			pos_wa = req.pos_addr[AW-1:0];
			sfx_wa = req.sfx_addr;
		end else if (wb_s1) begin
			pos_we = pos_s1;
			sfx_we = sfx_s1;
			case (op_s1)
				OP_OR: begin
					pos_wd = pos_rdata | bits_s1;
					sfx_wd = sfx_rdata | bits_s1;
				end
				OP_ANDN: begin
					pos_wd = pos_rdata & ~bits_s1;
					sfx_wd = sfx_rdata & ~bits_s1;
				end
				default: begin
					pos_we = 1'b0;
					sfx_we = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pos_we) pos_mem[pos_wa] <= pos_wd;
		if (issue && req.pos_en) pos_rdata <= pos_mem[req.pos_addr[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (sfx_we) sfx_mem[sfx_wa] <= sfx_wd;
		if (issue && req.sfx_en) sfx_rdata <= sfx_mem[req.sfx_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wb_s1 <= 1'b0;
		end else begin
			wb_s1 <= issue && (req.op != OP_READ);
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			pos_s1      <= req.pos_en;
			sfx_s1      <= req.sfx_en;
			op_s1       <= req.op;
			pos_addr_s1 <= req.pos_addr[AW-1:0];
			sfx_addr_s1 <= req.sfx_addr;
			bits_s1     <= req.bits[WORD_COUNT-1:0];
		end
	end

endmodule
`default_nettype wire

// ===== sv/variadic_word_class_matcher.sv =====
// Word class matcher for a lexer: each of up to MAX_POSITIONS character
// positions has a 256-entry table of word bits in one synchronous memory,
// next to a 256-entry suffix table. After reset a clearing pass zeroes
// both memories; no request is taken then. A match character makes one
// table read, whose result is folded into the running mask the cycle
// after. Set-up requests walk the tables one entry per cycle through a
// read-modify-write stage: a range walks its characters at one position, a
// repeating range at each position from the given one to the highest in
// use, a suffix writes one entry, and a removal walks all entries.
// A result waiting on the output does not block intake; a following match
// waits for the output slot before its table read.
`default_nettype none
module variadic_word_class_matcher import vwcm_pkg::*; #(
	parameter int MAX_POSITIONS = MaxPositionsDef,
	parameter int WORD_COUNT    = WordCountDef
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// character[7:0], range_end[15:8], position[19:16], word_mask[51:20],
	// new_match[52], past_end[53], zero fill
	input  wire logic [55:0] s_tdata,
	// kind[2:0]
	input  wire logic [2:0]  s_tuser,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// match_length[4:0], found[5], word_index[10:6], zero fill
	output logic [15:0]      m_tdata
);

`include "variadic_word_class_matcher_macros.svh"

	localparam int PW  = (MAX_POSITIONS > 1) ? $clog2(MAX_POSITIONS) : 1;
	localparam int UW  = $clog2(MAX_POSITIONS + 1);
	localparam int Cap = (MAX_POSITIONS < 30) ? MAX_POSITIONS : 30;
	localparam logic [WORD_COUNT-1:0] AllWords = '1;

	logic [7:0]            in_char;
	logic [7:0]            in_rend;
	logic [3:0]            in_pos;
	logic [WORD_COUNT-1:0] in_bits;
	logic                  in_new;
	logic                  in_past;
	logic                  accept;
	logic                  pos_ok;
	logic [UW-1:0]         piu_new;

	state_t                state_q, state_d;
	logic [2:0]            kind_q;
	logic [7:0]            ch_q;
	logic [7:0]            lo_q;
	logic [7:0]            hi_q;
	logic [WORD_COUNT-1:0] bits_q;
	logic                  start_q;
	logic                  past_q;
	logic                  nop_q;
	logic [PW-1:0]         p_q;
	logic [7:0]            c_q;
	logic [PW-1:0]         last_p_q;

	logic [WORD_COUNT-1:0] sfx_words_q;
	logic [UW-1:0]         piu_q;
	logic [WORD_COUNT-1:0] run_q;
	logic [WORD_COUNT-1:0] acc_q;
	logic [PW-1:0]         mp_q;
	logic [4:0]            cnt_q;
	logic                  active_q;

	logic                  out_valid_q;
	logic [15:0]           out_data_q;

	mem_req_t              req;
	logic                  done;
	logic                  step;
	logic                  wrap;
	logic                  issue_match;
	logic                  out_free;
	logic [PW-1:0]         idx;

	logic                  mvalid_s1;
	logic                  start_s1;
	logic                  past_s1;
	logic [WORD_COUNT-1:0] pos_rdata;
	logic [WORD_COUNT-1:0] sfx_rdata;

	logic [WORD_COUNT-1:0] e_run;
	logic [WORD_COUNT-1:0] e_acc;
	logic [4:0]            e_cnt;
	logic [PW-1:0]         e_mp;
	logic [WORD_COUNT-1:0] nxt;
	logic                  go_on;
	logic [WORD_COUNT-1:0] sfx_hit;
	logic [WORD_COUNT-1:0] fin_mask;
	logic [4:0]            fin_len;
	logic                  fin_found;
	logic [4:0]            fin_idx;
	logic                  res_s1;

	assign in_char = s_tdata[7:0];
	assign in_rend = s_tdata[15:8];
	assign in_pos  = s_tdata[19:16];
	assign in_bits = s_tdata[20 +: WORD_COUNT];
	assign in_new  = s_tdata[52];
	assign in_past = s_tdata[53];

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign pos_ok   = (32'(in_pos) < 32'(MAX_POSITIONS));
	assign piu_new  = (32'(piu_q) < 32'(in_pos) + 32'd1) ? UW'(32'(in_pos) + 32'd1) : piu_q;
	assign out_free = !out_valid_q || m_tready;
	assign idx      = start_q ? '0 : mp_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: if (c_q == 8'hFF && p_q == PW'(MAX_POSITIONS - 1)) state_d = ST_IDLE;
			ST_IDLE:  if (accept) state_d = ST_RUN;
			ST_RUN:   if (done) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// memory requests and sweep control
	always_comb begin
		req         = '0;
		done        = 1'b0;
		step        = 1'b0;
		issue_match = 1'b0;
		req.pos_addr = ReqAddrW'({p_q, c_q});
		req.sfx_addr = c_q;
		req.bits     = ReqBitsW'(bits_q);
		case (state_q)
			ST_CLEAR: begin
				req.valid  = 1'b1;
				req.op     = OP_ZERO;
				req.pos_en = 1'b1;
				req.sfx_en = (p_q == '0);
				step       = 1'b1;
			end
			ST_RUN: begin
				if (nop_q) begin
					done = 1'b1;
				end else begin
					case (kind_q)
						K_MATCH: begin
							if (!start_q && !active_q) begin
								done = 1'b1;
							end else if (out_free) begin
								req.valid    = 1'b1;
								req.op       = OP_READ;
								req.pos_en   = 1'b1;
								req.sfx_en   = 1'b1;
								req.pos_addr = ReqAddrW'({idx, ch_q});
								req.sfx_addr = ch_q;
								issue_match  = 1'b1;
								done         = 1'b1;
							end
						end
						K_RANGE: begin
							req.valid  = 1'b1;
							req.op     = OP_OR;
							req.pos_en = 1'b1;
							step       = 1'b1;
							done       = (c_q == hi_q);
						end
						K_RANGE_REP: begin
							req.valid  = 1'b1;
							req.op     = OP_OR;
							req.pos_en = 1'b1;
							step       = 1'b1;
							done       = (c_q == hi_q) && (p_q == last_p_q);
						end
						K_SUFFIX: begin
							req.valid    = 1'b1;
							req.op       = OP_OR;
							req.sfx_en   = 1'b1;
							req.sfx_addr = ch_q;
							done         = 1'b1;
						end
						K_REMOVE: begin
							req.valid  = 1'b1;
							req.op     = OP_ANDN;
							req.pos_en = 1'b1;
							step       = 1'b1;
							done       = (c_q == hi_q) && (p_q == PW'(MAX_POSITIONS - 1));
						end
						default: done = 1'b1;
					endcase
				end
			end
			default: ;
		endcase
	end

	assign wrap = (state_q == ST_CLEAR) ? (c_q == 8'hFF) : (c_q == hi_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			p_q         <= '0;
			c_q         <= '0;
			sfx_words_q <= '0;
			piu_q       <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				case (kind_t'(s_tuser))
					K_RANGE, K_RANGE_REP: begin
						if (pos_ok) piu_q <= piu_new;
						p_q <= PW'(in_pos);
						c_q <= in_char;
					end
					K_SUFFIX: sfx_words_q <= sfx_words_q | in_bits;
					K_REMOVE: begin
						p_q <= '0;
						c_q <= '0;
					end
					default: ;
				endcase
			end else if (step) begin
				if (wrap) begin
					c_q <= (state_q == ST_CLEAR) ? 8'h00 : lo_q;
					p_q <= p_q + PW'(1);
				end else begin
					c_q <= c_q + 8'd1;
				end
			end
		end
	end

	// request payload
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q   <= s_tuser;
			ch_q     <= in_char;
			lo_q     <= in_char;
			hi_q     <= in_rend;
			bits_q   <= in_bits;
			start_q  <= in_new;
			past_q   <= in_past;
			last_p_q <= PW'(32'(piu_new) - 32'd1);
			nop_q    <= 1'b0;
			case (kind_t'(s_tuser))
				K_MATCH, K_SUFFIX: ;
				K_RANGE, K_RANGE_REP: nop_q <= !pos_ok || (in_char > in_rend);
				K_REMOVE: begin
					lo_q <= 8'h00;
					hi_q <= 8'hFF;
				end
				default: nop_q <= 1'b1;
			endcase
		end
	end

	vwcm_store #(
		.MAX_POSITIONS (MAX_POSITIONS),
		.WORD_COUNT    (WORD_COUNT)
	) u_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.pos_rdata (pos_rdata),
		.sfx_rdata (sfx_rdata)
	);

	// match evaluation on the table read
	always_comb begin
		e_run = start_s1 ? AllWords : run_q;
		e_acc = start_s1 ? '0 : acc_q;
		e_cnt = start_s1 ? 5'd0 : cnt_q;
		e_mp  = start_s1 ? '0 : mp_q;
		nxt   = e_run & pos_rdata;
		go_on = (nxt != '0) && !past_s1 && (e_cnt < 5'(Cap)) && (piu_q != '0);
		sfx_hit  = past_s1 ? '0 : (e_acc & sfx_rdata);
		fin_mask = e_acc;
		fin_len  = e_cnt;
		if ((sfx_words_q & e_acc) != '0) begin
			if (sfx_hit != '0) begin
				fin_len  = e_cnt + 5'd1;
				fin_mask = sfx_hit;
			end else begin
				fin_mask = e_acc & ~sfx_words_q;
			end
		end
		if (piu_q == '0) begin
			fin_len  = 5'd0;
			fin_mask = '0;
		end
		fin_found = (fin_len != 5'd0) && (fin_mask != '0);
		fin_idx   = 5'd0;
		for (int i = 0; i < WORD_COUNT; i++) begin
			if (fin_mask[i]) fin_idx = 5'(i);
		end
		if (!fin_found) fin_idx = 5'd0;
		res_s1 = mvalid_s1 && !go_on;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mvalid_s1   <= 1'b0;
			run_q       <= '0;
			acc_q       <= '0;
			mp_q        <= '0;
			cnt_q       <= '0;
			active_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			mvalid_s1 <= issue_match;
			if (mvalid_s1) begin
				if (go_on) begin
					run_q    <= nxt;
					acc_q    <= nxt;
					cnt_q    <= e_cnt + 5'd1;
					mp_q     <= (32'(e_mp) + 32'd1 < 32'(piu_q)) ? e_mp + PW'(1) : e_mp;
					active_q <= 1'b1;
				end else begin
					active_q <= 1'b0;
				end
			end
			if (res_s1) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (issue_match) begin
			start_s1 <= start_q;
			past_s1  <= past_q;
		end
		if (res_s1) out_data_q <= {5'd0, fin_idx, fin_found, fin_len};
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	`VWCM_ASSERT_IMP(a_out_slot_free, mvalid_s1, !out_valid_q, "result slot busy at table read")
	`VWCM_ASSERT_IMP(a_pos_in_range, piu_q != '0, 32'(mp_q) < 32'(piu_q), "match position beyond allocation")
	`VWCM_ASSERT(a_count_cap, cnt_q <= 5'(Cap), "match count above cap")

endmodule
`default_nettype wire
